[rtl/core/atkinson_dither_stream_core_defines.svh]
// Assertion helpers for the dither core checker.
`ifndef ATKINSON_DITHER_STREAM_CORE_DEFINES_SVH
`define ATKINSON_DITHER_STREAM_CORE_DEFINES_SVH

// Clocked property, switched off while reset is high.
`define ADS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ads_checker: property failed");

// Clocked property that also holds across reset.
`define ADS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("ads_checker: property failed");

`endif

[rtl/core/ads_pkg.sv]
package ads_pkg;

   localparam int ADS_ROW_CAPACITY = 512;

   localparam int ADS_WIDTH_W  = 10;
   localparam int ADS_THRESH_W = 8;
   localparam int ADS_CSR_IDX_W = 4;

   localparam logic [ADS_WIDTH_W-1:0]  ADS_WIDTH_RESET  = 10'd384;
   localparam logic [ADS_THRESH_W-1:0] ADS_THRESH_RESET = 8'd128;

   localparam logic [ADS_CSR_IDX_W-1:0] ADS_REG_IMAGE_WIDTH = 4'd0;
   localparam logic [ADS_CSR_IDX_W-1:0] ADS_REG_THRESHOLD   = 4'd1;

   localparam logic [7:0] ADS_WHITE_LEVEL = 8'd255;
   localparam int         ADS_SHARE_SHIFT = 3;

   // An error share spans -31..31.
   typedef logic signed [5:0] ads_share_type;
   localparam ads_share_type ADS_SHARE_ZERO = 6'sd0;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] pixel_level;
   } ads_req_type;

   typedef struct packed {
      logic dot_white;
      logic row_end;
   } ads_rsp_type;

   typedef struct packed {
      logic [ADS_CSR_IDX_W-1:0] index;
      logic [ADS_WIDTH_W-1:0]   data;
   } ads_csr_type;

   typedef struct packed {
      logic [ADS_WIDTH_W-1:0]  image_width;
      logic [ADS_THRESH_W-1:0] threshold;
   } ads_cfg_type;

   // Pixel held between the share store read and the result register.
   typedef struct packed {
      logic       valid;
      logic [7:0] level;
      logic       use_older;
      logic       use_prev;
      logic       c_ge1;
      logic       c_ge2;
      logic       last;
      logic       clamped;
      logic       sel;
   } ads_slot_type;

endpackage

[rtl/core/ads_stream_if.sv]
interface ads_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/atkinson_dither_stream_core.sv]
// An accepted pixel waits in the slot register beside its registered share store
// reads; its dot moves into the result register when the slot advances.
// Throughput: one pixel per clock; the share stores give two reads and one
// write per bank each cycle, which sets that rate. A held dot stalls input.
// Reset (synchronous, active high) clears column, row count, left shares and
// all valid flags; the share stores are not cleared, the row count masks them.
module atkinson_dither_stream_core #(
   parameter int ROW_CAPACITY = ads_pkg::ADS_ROW_CAPACITY
) (
   input  logic          clock,
   input  logic          reset,
   ads_stream_if.sink    req_if,
   ads_stream_if.source  rsp_if,
   ads_stream_if.sink    csr_if
);

   localparam int CW = $clog2(ROW_CAPACITY);

   ads_pkg::ads_cfg_type   cfg;
   ads_pkg::ads_slot_type  slot;
   logic [CW-1:0]          slot_col;
   logic                   advance;
   logic                   rd_en;
   logic [CW-1:0]          rd_addr_a, rd_addr_b;
   logic                   wr_en0, wr_en1;
   ads_pkg::ads_share_type wr_share;
   ads_pkg::ads_share_type bank0_a, bank0_b, bank1_a, bank1_b;

   ads_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_if.valid),
      .csr_ready   (csr_if.ready),
      .csr_payload (csr_if.payload),
      .cfg         (cfg)
   );

   ads_front #(.ROW_CAPACITY(ROW_CAPACITY)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .image_width (cfg.image_width),
      .advance     (advance),
      .slot        (slot),
      .slot_col    (slot_col),
      .rd_en       (rd_en),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b)
   );

   ads_share_ram #(.DEPTH(ROW_CAPACITY)) u_bank0 (
      .clock     (clock),
      .wr_en     (wr_en0),
      .wr_addr   (slot_col),
      .wr_data   (wr_share),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (bank0_a),
      .rd_data_b (bank0_b)
   );

   ads_share_ram #(.DEPTH(ROW_CAPACITY)) u_bank1 (
      .clock     (clock),
      .wr_en     (wr_en1),
      .wr_addr   (slot_col),
      .wr_data   (wr_share),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (bank1_a),
      .rd_data_b (bank1_b)
   );

   ads_back u_back (
      .clock       (clock),
      .reset       (reset),
      .slot        (slot),
      .bank0_a     (bank0_a),
      .bank0_b     (bank0_b),
      .bank1_a     (bank1_a),
      .bank1_b     (bank1_b),
      .threshold   (cfg.threshold),
      .rsp_ready   (rsp_if.ready),
      .advance     (advance),
      .rsp_valid   (rsp_if.valid),
      .rsp_payload (rsp_if.payload),
      .wr_en0      (wr_en0),
      .wr_en1      (wr_en1),
      .wr_share    (wr_share)
   );

endmodule

[rtl/core/ads_csr.sv]
module ads_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  ads_pkg::ads_csr_type csr_payload,
   output ads_pkg::ads_cfg_type cfg
);

   ads_pkg::ads_cfg_type cfg_ff, cfg_in;

   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_payload.index)
            ads_pkg::ADS_REG_IMAGE_WIDTH: cfg_in.image_width = csr_payload.data;
            ads_pkg::ADS_REG_THRESHOLD:
               cfg_in.threshold = csr_payload.data[ads_pkg::ADS_THRESH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width <= ads_pkg::ADS_WIDTH_RESET;
         cfg_ff.threshold   <= ads_pkg::ADS_THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/ads_share_ram.sv]
module ads_share_ram #(
   parameter int  DEPTH = ads_pkg::ADS_ROW_CAPACITY,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  ads_pkg::ads_share_type wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   output ads_pkg::ads_share_type rd_data_a,
   output ads_pkg::ads_share_type rd_data_b
);

   ads_pkg::ads_share_type mem_ff [DEPTH];
   ads_pkg::ads_share_type rd_a_ff, rd_b_ff;

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Pass a same-cycle write straight through to the read register.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem_ff[rd_addr_a];
         rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem_ff[rd_addr_b];
      end
   end

endmodule

[rtl/core/ads_front.sv]
module ads_front #(
   parameter int  ROW_CAPACITY = ads_pkg::ADS_ROW_CAPACITY,
   localparam int CW           = $clog2(ROW_CAPACITY),
   localparam int WW           = $clog2(ROW_CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ads_pkg::ads_req_type                 req_payload,
   input  logic [ads_pkg::ADS_WIDTH_W-1:0]      image_width,
   input  logic                                advance,
   output ads_pkg::ads_slot_type                slot,
   output logic [CW-1:0]                        slot_col,
   output logic                                rd_en,
   output logic [CW-1:0]                        rd_addr_a,
   output logic [CW-1:0]                        rd_addr_b
);

   localparam int CMPW = (WW > ads_pkg::ADS_WIDTH_W) ? WW : ads_pkg::ADS_WIDTH_W;
   localparam logic [CMPW-1:0] MAX_EXT = CMPW'(ROW_CAPACITY);

   logic [CW-1:0]   column_ff, column_in;
   logic [1:0]      rows_ff, rows_in;
   logic            sel_ff, sel_in;
   ads_pkg::ads_slot_type slot_ff, slot_in;
   logic [CW-1:0]   col_ff, col_in;

   logic            accept;
   logic [CMPW-1:0] width_ext;
   logic [WW-1:0]   width_eff;
   logic [CW-1:0]   col_cur;
   logic [1:0]      rows_cur;
   logic            clamped;
   logic [CW-1:0]   col;
   logic            last;

   assign req_ready = !reset && (!slot_ff.valid || advance);
   assign accept    = req_valid && req_ready;
   assign slot      = slot_ff;
   assign slot_col  = col_ff;
   assign rd_en     = accept;
   assign rd_addr_a = col;
   // A clamped column always ends its row, so the right tap is free for c-1.
   assign rd_addr_b = clamped ? col - CW'(1) : col + CW'(1);

   always_comb begin
      width_ext = CMPW'(image_width);
      if (width_ext == '0) begin
         width_eff = WW'(1);
      end else if (width_ext > MAX_EXT) begin
         width_eff = WW'(ROW_CAPACITY);
      end else begin
         width_eff = width_ext[WW-1:0];
      end

      col_cur  = req_payload.frame_start ? '0 : column_ff;
      rows_cur = req_payload.frame_start ? 2'd0 : rows_ff;
      clamped  = WW'(col_cur) >= width_eff;
      col      = clamped ? CW'(width_eff - WW'(1)) : col_cur;
      last     = (WW'(col) + WW'(1)) >= width_eff;
   end

   always_comb begin
      column_in = column_ff;
      rows_in   = rows_ff;
      sel_in    = sel_ff;
      col_in    = col_ff;
      slot_in   = slot_ff;
      if (advance) begin
         slot_in.valid = 1'b0;
      end
      if (accept) begin
         col_in            = col;
         slot_in.valid     = 1'b1;
         slot_in.level     = req_payload.pixel_level;
         slot_in.use_older = rows_cur[1];
         slot_in.use_prev  = rows_cur != 2'd0;
         slot_in.c_ge1     = col != '0;
         slot_in.c_ge2     = |col[CW-1:1];
         slot_in.last      = last;
         slot_in.clamped   = clamped;
         slot_in.sel       = sel_ff;
         if (last) begin
            // Swap row stores by flipping the bank select.
            column_in = '0;
            rows_in   = rows_cur[1] ? rows_cur : rows_cur + 2'd1;
            sel_in    = !sel_ff;
         end else begin
            column_in = col + CW'(1);
            rows_in   = rows_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         rows_ff       <= 2'd0;
         sel_ff        <= 1'b0;
         slot_ff.valid <= 1'b0;
      end else begin
         column_ff <= column_in;
         rows_ff   <= rows_in;
         sel_ff    <= sel_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

endmodule

[rtl/core/ads_back.sv]
module ads_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ads_pkg::ads_slot_type                slot,
   input  ads_pkg::ads_share_type               bank0_a,
   input  ads_pkg::ads_share_type               bank0_b,
   input  ads_pkg::ads_share_type               bank1_a,
   input  ads_pkg::ads_share_type               bank1_b,
   input  logic [ads_pkg::ADS_THRESH_W-1:0]     threshold,
   input  logic                                rsp_ready,
   output logic                                advance,
   output logic                                rsp_valid,
   output ads_pkg::ads_rsp_type                 rsp_payload,
   output logic                                wr_en0,
   output logic                                wr_en1,
   output ads_pkg::ads_share_type               wr_share
);

   function automatic logic [7:0] sat_add(input logic [7:0] level,
                                          input ads_pkg::ads_share_type share);
      logic signed [9:0] sum;
      sum = $signed({2'b00, level}) + $signed({{4{share[5]}}, share});
      if (sum < 0) begin
         return 8'd0;
      end else if (sum > 10'sd255) begin
         return 8'd255;
      end else begin
         return sum[7:0];
      end
   endfunction

   ads_pkg::ads_share_type left_ff, left_in;
   ads_pkg::ads_share_type second_left_ff, second_left_in;
   ads_pkg::ads_share_type prev_left_ff, prev_left_in;
   logic                   out_valid_ff, out_valid_in;
   ads_pkg::ads_rsp_type   out_ff, out_in;

   ads_pkg::ads_share_type prev_mid, prev_right, older_mid, prev_left, share;
   logic [7:0]             lv1, lv2, lv3, lv4, lv5, lv6;
   logic                   white;
   logic [4:0]             mag;

   assign advance     = slot.valid && (!out_valid_ff || rsp_ready);
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign wr_en0      = advance && slot.sel;
   assign wr_en1      = advance && !slot.sel;
   assign wr_share    = share;

   always_comb begin
      prev_mid   = slot.sel ? bank1_a : bank0_a;
      prev_right = slot.sel ? bank1_b : bank0_b;
      older_mid  = slot.sel ? bank0_a : bank1_a;
      prev_left  = slot.clamped ? prev_right : prev_left_ff;

      // Clamp after every addition, in the fixed neighbour order.
      lv1 = sat_add(slot.level, slot.use_older ? older_mid : ads_pkg::ADS_SHARE_ZERO);
      lv2 = sat_add(lv1, (slot.use_prev && slot.c_ge1) ? prev_left
                                                       : ads_pkg::ADS_SHARE_ZERO);
      lv3 = sat_add(lv2, slot.use_prev ? prev_mid : ads_pkg::ADS_SHARE_ZERO);
      lv4 = sat_add(lv3, (slot.use_prev && !slot.last) ? prev_right
                                                       : ads_pkg::ADS_SHARE_ZERO);
      lv5 = sat_add(lv4, slot.c_ge2 ? second_left_ff : ads_pkg::ADS_SHARE_ZERO);
      lv6 = sat_add(lv5, slot.c_ge1 ? left_ff : ads_pkg::ADS_SHARE_ZERO);

      white = lv6 >= threshold;
      // Truncate toward zero: shift the magnitude, then restore the sign.
      mag   = white ? 5'((ads_pkg::ADS_WHITE_LEVEL - lv6) >> ads_pkg::ADS_SHARE_SHIFT)
                    : 5'(lv6 >> ads_pkg::ADS_SHARE_SHIFT);
      share = white ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_comb begin
      left_in        = left_ff;
      second_left_in = second_left_ff;
      prev_left_in   = prev_left_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         left_in          = share;
         second_left_in   = left_ff;
         prev_left_in     = prev_mid;
         out_valid_in     = 1'b1;
         out_in.dot_white = white;
         out_in.row_end   = slot.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff        <= ads_pkg::ADS_SHARE_ZERO;
         second_left_ff <= ads_pkg::ADS_SHARE_ZERO;
         out_valid_ff   <= 1'b0;
      end else begin
         left_ff        <= left_in;
         second_left_ff <= second_left_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_left_ff <= prev_left_in;
      out_ff       <= out_in;
   end

endmodule

[rtl/core/ads_checker.sv]
`include "atkinson_dither_stream_core_defines.svh"

module ads_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A stalled result stays offered.
   `ADS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   // With the result side free, the input side never stalls.
   `ADS_ASSERT(a_req_free, !(rsp_valid && !rsp_ready) |-> req_ready)
   // Every accepted transaction is followed by a result on offer.
   `ADS_ASSERT(a_rsp_follows, req_valid && req_ready |-> ##2 rsp_valid)
   // Reset drops any pending result.
   `ADS_ASSERT_ALWAYS(a_reset_drop, reset |=> !rsp_valid)

endmodule

bind atkinson_dither_stream_core ads_checker u_ads_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready)
);
